[hdl/b64dec_pkg.sv]
// shared types and character constants for the base64 decoder
`timescale 1ns / 1ps
`default_nettype none

package b64dec_pkg;

  localparam logic [7:0] CHAR_PAD        = 8'h3D;
  localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;
  localparam logic [7:0] CHAR_DIGIT_0    = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9    = 8'h39;
  localparam logic [7:0] CHAR_PLUS       = 8'h2B;
  localparam logic [7:0] CHAR_MINUS      = 8'h2D;
  localparam logic [7:0] CHAR_SLASH      = 8'h2F;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

  localparam logic [5:0] LOWER_BASE = 6'd26;
  localparam logic [5:0] DIGIT_BASE = 6'd52;
  localparam logic [5:0] SEXTET_62  = 6'd62;
  localparam logic [5:0] SEXTET_63  = 6'd63;

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;
  localparam logic [1:0] POS_FOURTH = 2'd3;

  typedef struct packed {
    logic [5:0] sextet;
    logic       ok;
    logic       is_pad;
  } char_class_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       failed;
  } dec_result_t;

  typedef struct packed {
    logic [1:0] group_position;
    logic       pad_seen;
    logic       error_flag;
  } dec_status_t;

endpackage

`default_nettype wire

[hdl/b64dec_char_map.sv]
// character to sextet map covering both alphabets
`timescale 1ns / 1ps
`default_nettype none

module b64dec_char_map (
  input  wire logic [7:0]            char_code,
  output b64dec_pkg::char_class_t    char_class
);

  always_comb begin
    char_class.sextet = '0;
    char_class.ok     = 1'b0;
    char_class.is_pad = (char_code == b64dec_pkg::CHAR_PAD);
    if (char_code >= b64dec_pkg::CHAR_UPPER_A && char_code <= b64dec_pkg::CHAR_UPPER_Z) begin
      char_class.sextet = 6'(char_code - b64dec_pkg::CHAR_UPPER_A);
      char_class.ok     = 1'b1;
    end else if (char_code >= b64dec_pkg::CHAR_LOWER_A &&
                 char_code <= b64dec_pkg::CHAR_LOWER_Z) begin
      char_class.sextet = 6'(char_code - b64dec_pkg::CHAR_LOWER_A) + b64dec_pkg::LOWER_BASE;
      char_class.ok     = 1'b1;
    end else if (char_code >= b64dec_pkg::CHAR_DIGIT_0 &&
                 char_code <= b64dec_pkg::CHAR_DIGIT_9) begin
      char_class.sextet = 6'(char_code - b64dec_pkg::CHAR_DIGIT_0) + b64dec_pkg::DIGIT_BASE;
      char_class.ok     = 1'b1;
    end else if (char_code == b64dec_pkg::CHAR_PLUS || char_code == b64dec_pkg::CHAR_MINUS) begin
      char_class.sextet = b64dec_pkg::SEXTET_62;
      char_class.ok     = 1'b1;
    end else if (char_code == b64dec_pkg::CHAR_SLASH ||
                 char_code == b64dec_pkg::CHAR_UNDERSCORE) begin
      char_class.sextet = b64dec_pkg::SEXTET_63;
      char_class.ok     = 1'b1;
    end
  end

endmodule

`default_nettype wire

[hdl/b64dec_group.sv]
// group state and byte assembly for the base64 decoder
`timescale 1ns / 1ps
`default_nettype none

module b64dec_group (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire logic                  final_char,
  input  wire b64dec_pkg::char_class_t char_class,
  output b64dec_pkg::dec_result_t    result,
  output b64dec_pkg::dec_status_t    status
);

  logic [1:0] group_position, group_position_next;
  logic [5:0] held_sextet, held_sextet_next;
  logic       held_invalid, held_invalid_next;
  logic       pad_seen, pad_seen_next;
  logic       error_flag, error_flag_next;

  always_comb begin
    group_position_next = group_position;
    held_sextet_next    = held_sextet;
    held_invalid_next   = held_invalid;
    pad_seen_next       = pad_seen;
    error_flag_next     = error_flag;
    result.out_byte     = '0;
    result.byte_present = 1'b0;
    if (char_class.is_pad) begin
      pad_seen_next = 1'b1;
    end else if (pad_seen) begin
      error_flag_next = 1'b1;
    end else begin
      held_sextet_next = char_class.sextet;
      unique case (group_position)
        b64dec_pkg::POS_FIRST: begin
          held_invalid_next   = !char_class.ok;
          group_position_next = b64dec_pkg::POS_SECOND;
        end
        b64dec_pkg::POS_SECOND: begin
          if (held_invalid || !char_class.ok) begin
            error_flag_next = 1'b1;
          end else if (!error_flag) begin
            result.out_byte     = {held_sextet, char_class.sextet[5:4]};
            result.byte_present = 1'b1;
          end
          held_invalid_next   = 1'b0;
          group_position_next = b64dec_pkg::POS_THIRD;
        end
        b64dec_pkg::POS_THIRD: begin
          if (!char_class.ok) begin
            error_flag_next = 1'b1;
          end else if (!error_flag) begin
            result.out_byte     = {held_sextet[3:0], char_class.sextet[5:2]};
            result.byte_present = 1'b1;
          end
          group_position_next = b64dec_pkg::POS_FOURTH;
        end
        default: begin
          if (!char_class.ok) begin
            error_flag_next = 1'b1;
          end else if (!error_flag) begin
            result.out_byte     = {held_sextet[1:0], char_class.sextet};
            result.byte_present = 1'b1;
          end
          group_position_next = b64dec_pkg::POS_FIRST;
        end
      endcase
    end
    result.failed = error_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && final_char)) begin
      group_position <= b64dec_pkg::POS_FIRST;
      held_sextet    <= '0;
      held_invalid   <= 1'b0;
      pad_seen       <= 1'b0;
      error_flag     <= 1'b0;
    end else if (step) begin
      group_position <= group_position_next;
      held_sextet    <= held_sextet_next;
      held_invalid   <= held_invalid_next;
      pad_seen       <= pad_seen_next;
      error_flag     <= error_flag_next;
    end
  end

  assign status.group_position = group_position;
  assign status.pad_seen       = pad_seen;
  assign status.error_flag     = error_flag;

endmodule

`default_nettype wire

[hdl/base64_dual_alphabet_decoder.sv]
// top level of the streaming base64 decoder, both alphabets
//
// channel  direction  handshake            payload
// in       sink       in_valid / in_ready  char_code, final_char
// out      source     out_valid/ out_ready out_byte, byte_present, failed, message_end
//
// one beat in, one beat out; a new character is taken every cycle while the output is not stalled
// registered path: input register, then the map and group logic into the result register
// group state advances only when a character moves into the result register
// a stalled output holds the result; the input register still takes one more beat
// synchronous reset clears both valid flags and the group state
`timescale 1ns / 1ps
`default_nettype none

module base64_dual_alphabet_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] char_code,
  input  wire logic       final_char,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            byte_present,
  output logic            failed,
  output logic            message_end
);

  logic                    s1_valid;
  logic [7:0]              s1_char;
  logic                    s1_final;
  logic                    step;
  b64dec_pkg::char_class_t char_class;
  b64dec_pkg::dec_result_t result;
  b64dec_pkg::dec_status_t status;

  assign step     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char  <= char_code;
      s1_final <= final_char;
    end
  end

  b64dec_char_map u_char_map (
    .char_code  (s1_char),
    .char_class (char_class)
  );

  b64dec_group u_group (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .final_char (s1_final),
    .char_class (char_class),
    .result     (result),
    .status     (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte     <= result.out_byte;
      byte_present <= result.byte_present;
      failed       <= result.failed;
      message_end  <= s1_final;
    end
  end

  a_byte_not_failed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(byte_present && failed))
    else $error("byte delivered with error flag set");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    step && s1_final |=> (status.group_position == b64dec_pkg::POS_FIRST) &&
                         !status.pad_seen && !status.error_flag)
    else $error("state not cleared after final character");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    status.error_flag && !(step && s1_final) |=> status.error_flag)
    else $error("error flag dropped inside a message");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output is draining");

endmodule

`default_nettype wire

[test/base64_dual_alphabet_decoder_tb.sv]
// self-checking testbench for the dual-alphabet base64 decoder, directed table then random messages
`timescale 1ns / 1ps

module base64_dual_alphabet_decoder_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       failed;
    logic       message_end;
  } decoded_beat_t;

  typedef struct packed {
    logic [7:0]    code;
    logic          last;
    logic          literal;
    decoded_beat_t want;
  } script_row_t;

  localparam decoded_beat_t QUIET     = '{8'h00, 1'b0, 1'b0, 1'b0};
  localparam decoded_beat_t QUIET_END = '{8'h00, 1'b0, 1'b0, 1'b1};
  localparam decoded_beat_t FAIL      = '{8'h00, 1'b0, 1'b1, 1'b0};
  localparam decoded_beat_t FAIL_END  = '{8'h00, 1'b0, 1'b1, 1'b1};

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] char_code;
  logic       final_char;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       failed;
  logic       message_end;

  base64_dual_alphabet_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .final_char   (final_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .byte_present (byte_present),
    .failed       (failed),
    .message_end  (message_end)
  );

  // decoder state mirror
  logic [1:0] grp_pos;
  logic [5:0] prev_sextet;
  logic       prev_invalid;
  logic       pad_hit;
  logic       sticky_err;

  decoded_beat_t pending_beats[$];
  script_row_t   script[28];

  int   mismatches = 0;
  int   chars_sent = 0;
  int   cycles = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  logic hold_phase = 1'b0;
  logic hold_done = 1'b0;
  logic cur_literal = 1'b0;
  decoded_beat_t cur_want = QUIET;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
    if (c >= b64dec_pkg::CHAR_UPPER_A && c <= b64dec_pkg::CHAR_UPPER_Z)
      return {1'b1, 6'(c - b64dec_pkg::CHAR_UPPER_A)};
    if (c >= b64dec_pkg::CHAR_LOWER_A && c <= b64dec_pkg::CHAR_LOWER_Z)
      return {1'b1, 6'(c - b64dec_pkg::CHAR_LOWER_A) + b64dec_pkg::LOWER_BASE};
    if (c >= b64dec_pkg::CHAR_DIGIT_0 && c <= b64dec_pkg::CHAR_DIGIT_9)
      return {1'b1, 6'(c - b64dec_pkg::CHAR_DIGIT_0) + b64dec_pkg::DIGIT_BASE};
    if (c == b64dec_pkg::CHAR_PLUS || c == b64dec_pkg::CHAR_MINUS)
      return {1'b1, b64dec_pkg::SEXTET_62};
    if (c == b64dec_pkg::CHAR_SLASH || c == b64dec_pkg::CHAR_UNDERSCORE)
      return {1'b1, b64dec_pkg::SEXTET_63};
    return 7'd0;
  endfunction

  function automatic void clear_decoder();
    grp_pos = b64dec_pkg::POS_FIRST;
    prev_sextet = 6'd0;
    prev_invalid = 1'b0;
    pad_hit = 1'b0;
    sticky_err = 1'b0;
  endfunction

  function automatic decoded_beat_t decode_step(input logic [7:0] c, input logic last);
    decoded_beat_t r;
    logic [6:0] m;
    logic [5:0] v;
    logic ok;
    r = QUIET;
    r.message_end = last;
    m = char_to_sextet(c);
    ok = m[6];
    v = m[5:0];
    if (c == b64dec_pkg::CHAR_PAD) begin
      pad_hit = 1'b1;
    end else if (pad_hit) begin
      sticky_err = 1'b1;
    end else begin
      case (grp_pos)
        b64dec_pkg::POS_FIRST: begin
          prev_invalid = !ok;
        end
        b64dec_pkg::POS_SECOND: begin
          if (prev_invalid || !ok) begin
            sticky_err = 1'b1;
          end else if (!sticky_err) begin
            r.out_byte = {prev_sextet, v[5:4]};
            r.byte_present = 1'b1;
          end
          prev_invalid = 1'b0;
        end
        b64dec_pkg::POS_THIRD: begin
          if (!ok) begin
            sticky_err = 1'b1;
          end else if (!sticky_err) begin
            r.out_byte = {prev_sextet[3:0], v[5:2]};
            r.byte_present = 1'b1;
          end
        end
        default: begin
          if (!ok) begin
            sticky_err = 1'b1;
          end else if (!sticky_err) begin
            r.out_byte = {prev_sextet[1:0], v};
            r.byte_present = 1'b1;
          end
        end
      endcase
      grp_pos = grp_pos + 2'd1;
      prev_sextet = v;
    end
    r.failed = sticky_err;
    if (last) clear_decoder();
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // accepted beats in, results out
  always @(posedge clk) begin
    decoded_beat_t r;
    if (!rst) begin
      if (in_valid && in_ready) begin
        r = decode_step(char_code, final_char);
        pending_beats.insert(pending_beats.size(), cur_literal ? cur_want : r);
      end
      if (out_valid && out_ready) begin
        if (pending_beats.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected beat, expected none, actual %0h/%0b/%0b/%0b", $time,
                   out_byte, byte_present, failed, message_end);
        end else begin
          r = pending_beats.pop_front();
          check_field("out_byte", r.out_byte, out_byte);
          check_field("byte_present", r.byte_present, byte_present);
          check_field("failed", r.failed, failed);
          check_field("message_end", r.message_end, message_end);
        end
      end
    end
  end

  // receiver
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_phase && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("base64_dual_alphabet_decoder_tb: done, errors");
    $finish;
  end

  task automatic send_char(input logic [7:0] c, input logic last, input logic lit,
                           input decoded_beat_t want);
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    char_code <= c;
    final_char <= last;
    cur_literal = lit;
    cur_want = want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
  endtask

  function automatic logic [7:0] random_symbol();
    int unsigned v;
    v = $urandom_range(63);
    if (v < 26) return b64dec_pkg::CHAR_UPPER_A + 8'(v);
    if (v < 52) return b64dec_pkg::CHAR_LOWER_A + 8'(v - 26);
    if (v < 62) return b64dec_pkg::CHAR_DIGIT_0 + 8'(v - 52);
    if (v == 62) return $urandom_range(1) ? b64dec_pkg::CHAR_PLUS : b64dec_pkg::CHAR_MINUS;
    return $urandom_range(1) ? b64dec_pkg::CHAR_SLASH : b64dec_pkg::CHAR_UNDERSCORE;
  endfunction

  // mostly well-formed messages, some noisy, some with data after padding
  task automatic send_message();
    int unsigned len;
    int unsigned kind;
    int unsigned pads;
    int unsigned k;
    logic [7:0] c;
    kind = $urandom_range(9);
    len = $urandom_range(1, 12);
    pads = 0;
    if (kind < 7 && $urandom_range(2) == 0) pads = (4 - len % 4) % 4;
    for (k = 0; k < len + pads; k++) begin
      if (k >= len) c = b64dec_pkg::CHAR_PAD;
      else if (kind < 7) c = random_symbol();
      else if (kind == 7) c = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : random_symbol();
      else if (kind == 8) c = (k == len / 2) ? b64dec_pkg::CHAR_PAD : random_symbol();
      else c = 8'($urandom_range(255));
      send_char(c, k == len + pads - 1, 1'b0, QUIET);
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input int n);
    int target;
    idle_pct = idle;
    stall_pct = stall;
    target = chars_sent + n;
    while (chars_sent < target) send_message();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    char_code = 8'h00;
    final_char = 1'b0;
    clear_decoder();
    script = '{
      '{"T", 1'b0, 1'b1, QUIET},
      '{"W", 1'b0, 1'b0, QUIET},
      '{"F", 1'b0, 1'b0, QUIET},
      '{"u", 1'b1, 1'b0, QUIET},
      '{b64dec_pkg::CHAR_UNDERSCORE, 1'b0, 1'b0, QUIET},
      '{b64dec_pkg::CHAR_MINUS, 1'b0, 1'b0, QUIET},
      '{b64dec_pkg::CHAR_SLASH, 1'b0, 1'b0, QUIET},
      '{b64dec_pkg::CHAR_PLUS, 1'b0, 1'b0, QUIET},
      '{b64dec_pkg::CHAR_LOWER_Z, 1'b0, 1'b0, QUIET},
      '{b64dec_pkg::CHAR_DIGIT_0, 1'b0, 1'b0, QUIET},
      '{b64dec_pkg::CHAR_DIGIT_9, 1'b0, 1'b0, QUIET},
      '{b64dec_pkg::CHAR_LOWER_A, 1'b1, 1'b0, QUIET},
      '{b64dec_pkg::CHAR_UPPER_Z, 1'b0, 1'b0, QUIET},
      '{b64dec_pkg::CHAR_UPPER_A, 1'b0, 1'b0, QUIET},
      '{b64dec_pkg::CHAR_PAD, 1'b0, 1'b1, QUIET},
      '{b64dec_pkg::CHAR_PAD, 1'b1, 1'b1, QUIET_END},
      '{"Q", 1'b0, 1'b0, QUIET},
      '{"Q", 1'b0, 1'b0, QUIET},
      '{b64dec_pkg::CHAR_PAD, 1'b0, 1'b1, QUIET},
      '{"A", 1'b1, 1'b1, FAIL_END},
      '{"*", 1'b0, 1'b1, QUIET},
      '{"A", 1'b1, 1'b1, FAIL_END},
      '{"A", 1'b0, 1'b1, QUIET},
      '{8'hFF, 1'b0, 1'b1, FAIL},
      '{"B", 1'b0, 1'b1, FAIL},
      '{8'h80, 1'b1, 1'b1, FAIL_END},
      '{8'h00, 1'b1, 1'b1, QUIET_END},
      '{b64dec_pkg::CHAR_PAD, 1'b1, 1'b1, QUIET_END}
    };
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i])
      send_char(script[i].code, script[i].last, script[i].literal, script[i].want);

    run_phase(0, 0, 250);
    run_phase(51, 0, 250);
    run_phase(0, 51, 250);
    run_phase(29, 29, 250);

    // long output hold-off with the sender still pushing
    idle_pct = 0;
    stall_pct = 0;
    hold_phase = 1'b1;
    while (!hold_done) send_message();
    hold_phase = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("base64_dual_alphabet_decoder_tb: done, clean");
    end else begin
      $display("base64_dual_alphabet_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule
